// ----- rtl/core/lmrp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmrp_pkg
// shared widths, register indexes and the match request type of the
// lane marker row pair matcher
// ----------------------------------------------------------------------------
package lmrp_pkg;

  // field widths
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned Y_W    = 10;
  localparam int unsigned X_W    = 11;
  localparam int unsigned TOL_W  = 11;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned IDX_W  = 2;

  // edges closer than this never pair
  localparam logic [COL_W-1:0] MIN_SPACING = 10'd5;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_X_OFFSET  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_GAP   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MATCH_TOL = 2'd2;

  // configuration reset values
  localparam logic [COL_W-1:0] X_OFFSET_RST  = 10'd0;
  localparam logic [COL_W-1:0] MAX_GAP_RST   = 10'd50;
  localparam logic [TOL_W-1:0] MATCH_TOL_RST = 11'd1;

  // row end request from the edge unit to the match sequencer
  typedef struct packed {
    logic           start;
    logic           bank;    // bank holding the points of the closing row
    logic [Y_W-1:0] near_y;
    logic [Y_W-1:0] far_y;
  } match_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/lmrp_point_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmrp_point_ram
// one write port, one read port point memory with registered read data
// ----------------------------------------------------------------------------
module lmrp_point_ram #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned WIDTH  = 11,
  parameter int unsigned ADDR_W = 3
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]  wr_data_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/lmrp_edge_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmrp_edge_unit
// pairs edges within a scan row into marker points, writes them to the
// current point bank and swaps the banks at row end
// ----------------------------------------------------------------------------
module lmrp_edge_unit #(
  parameter int unsigned MAX_POINTS = 8,
  parameter int unsigned PT_IDX_W   = 3,
  parameter int unsigned PT_CNT_W   = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fire_i,
  input  wire logic [lmrp_pkg::SLOT_W-1:0]  row_slot_i,
  input  wire logic [lmrp_pkg::Y_W-1:0]     row_y_i,
  input  wire logic [lmrp_pkg::COL_W-1:0]   column_i,
  input  wire logic                         edge_req_i,
  input  wire logic                         row_end_i,
  input  wire logic [lmrp_pkg::COL_W-1:0]   x_offset_i,
  input  wire logic [lmrp_pkg::COL_W-1:0]   max_gap_i,
  output logic                              wr_en_o,
  output logic                              wr_bank_o,
  output logic      [PT_IDX_W-1:0]          wr_addr_o,
  output logic      [lmrp_pkg::X_W-1:0]     wr_data_o,
  output lmrp_pkg::match_req_t              req_o,
  output logic      [PT_CNT_W-1:0]          prev_cnt_o,
  output logic      [PT_CNT_W-1:0]          cur_cnt_o
);
  import lmrp_pkg::*;

  localparam logic [PT_CNT_W-1:0] CNT_FULL = PT_CNT_W'(MAX_POINTS);

  logic [COL_W-1:0]    last_col_q, last_col_d;
  logic [PT_CNT_W-1:0] cur_cnt_q, cur_cnt_d;
  logic [PT_CNT_W-1:0] prev_cnt_q, prev_cnt_d;
  logic [Y_W-1:0]      prev_y_q, prev_y_d;
  logic                bank_q, bank_d;

  logic [COL_W-1:0] col_dist;
  logic [COL_W-1:0] hi_col;
  logic [COL_W-1:0] half_mid;
  logic [X_W-1:0]   mid_x;
  logic             edge_hit;
  logic             pair_hit;
  logic             has_room;
  logic [PT_CNT_W-1:0] cnt_after;

  // distance, midpoint and pairing test
  always_comb begin
    edge_hit = edge_req_i && (column_i != '0);
    if (column_i > last_col_q) begin
      col_dist = column_i - last_col_q;
      hi_col   = column_i;
    end else begin
      col_dist = last_col_q - column_i;
      hi_col   = last_col_q;
    end
    half_mid = hi_col - {1'b0, col_dist[COL_W-1:1]};
    mid_x    = {1'b0, half_mid} + {1'b0, x_offset_i};
    pair_hit = edge_hit && (last_col_q != '0) && (col_dist > MIN_SPACING)
               && (col_dist < max_gap_i);
    has_room = cur_cnt_q < CNT_FULL;
  end

  // point write into the current bank
  assign wr_en_o   = fire_i && pair_hit && has_room;
  assign wr_bank_o = bank_q;
  assign wr_addr_o = cur_cnt_q[PT_IDX_W-1:0];
  assign wr_data_o = mid_x;

  // edge memory, counts and bank swap
  always_comb begin
    last_col_d = last_col_q;
    cur_cnt_d  = cur_cnt_q;
    prev_cnt_d = prev_cnt_q;
    prev_y_d   = prev_y_q;
    bank_d     = bank_q;
    cnt_after  = cur_cnt_q;
    if (fire_i && edge_hit) begin
      if (pair_hit) begin
        last_col_d = '0;
        if (has_room) begin
          cnt_after = cur_cnt_q + PT_CNT_W'(1);
        end
      end else begin
        last_col_d = column_i;
      end
    end
    cur_cnt_d = cnt_after;
    if (fire_i && row_end_i) begin
      last_col_d = '0;
      cur_cnt_d  = '0;
      prev_cnt_d = cnt_after;
      prev_y_d   = row_y_i;
      bank_d     = ~bank_q;
    end
  end

  // match request for the closing row
  always_comb begin
    req_o.start  = fire_i && row_end_i && (row_slot_i != '0)
                   && (prev_cnt_q != '0) && (cnt_after != '0);
    req_o.bank   = bank_q;
    req_o.near_y = prev_y_q;
    req_o.far_y  = row_y_i;
    prev_cnt_o   = prev_cnt_q;
    cur_cnt_o    = cnt_after;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= '0;
      cur_cnt_q  <= '0;
      prev_cnt_q <= '0;
      prev_y_q   <= '0;
      bank_q     <= 1'b0;
    end else begin
      last_col_q <= last_col_d;
      cur_cnt_q  <= cur_cnt_d;
      prev_cnt_q <= prev_cnt_d;
      prev_y_q   <= prev_y_d;
      bank_q     <= bank_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lmrp_match_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmrp_match_seq
// walks every previous row point against every current row point, reading
// both point banks, and emits matching pairs through an output register
// ----------------------------------------------------------------------------
module lmrp_match_seq #(
  parameter int unsigned PT_IDX_W = 3,
  parameter int unsigned PT_CNT_W = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lmrp_pkg::match_req_t        req_i,
  input  wire logic [PT_CNT_W-1:0]         prev_cnt_i,
  input  wire logic [PT_CNT_W-1:0]         cur_cnt_i,
  input  wire logic [lmrp_pkg::TOL_W-1:0]  match_tol_i,
  input  wire logic [lmrp_pkg::X_W-1:0]    prev_x_i,
  input  wire logic [lmrp_pkg::X_W-1:0]    cur_x_i,
  output logic      [PT_IDX_W-1:0]         prev_addr_o,
  output logic      [PT_IDX_W-1:0]         cur_addr_o,
  output logic                             rd_bank_o,
  output logic                             idle_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [lmrp_pkg::X_W-1:0]    near_x_o,
  output logic      [lmrp_pkg::Y_W-1:0]    near_y_o,
  output logic      [lmrp_pkg::X_W-1:0]    far_x_o,
  output logic      [lmrp_pkg::Y_W-1:0]    far_y_o,
  output logic                             segment_last_o
);
  import lmrp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FLUSH
  } state_e;

  state_e              state_q;
  logic [PT_IDX_W-1:0] i_q, u_q;
  logic [PT_CNT_W-1:0] prev_cnt_q, cur_cnt_q;
  logic [Y_W-1:0]      near_y_q, far_y_q;
  logic                bank_q;

  // held match, emitted once the next one is known or the walk ends
  logic                pend_v_q;
  logic [X_W-1:0]      pend_near_x_q, pend_far_x_q;

  logic                out_v_q;
  logic [X_W-1:0]      out_near_x_q, out_far_x_q;
  logic [Y_W-1:0]      out_near_y_q, out_far_y_q;
  logic                out_last_q;

  logic [X_W-1:0]      diff;
  logic                hit;
  logic                out_free;
  logic                cmp_go;
  logic                out_load;
  logic                u_end, i_end;

  // pair compare and loop end tests
  always_comb begin
    diff     = (prev_x_i > cur_x_i) ? (prev_x_i - cur_x_i) : (cur_x_i - prev_x_i);
    hit      = diff <= match_tol_i;
    out_free = !out_v_q || out_ready_i;
    cmp_go   = !hit || !pend_v_q || out_free;
    out_load = ((state_q == ST_CMP) && cmp_go && hit && pend_v_q)
               || ((state_q == ST_FLUSH) && pend_v_q && out_free);
    u_end    = ({1'b0, PT_CNT_W'(u_q)} + (PT_CNT_W+1)'(1)) == {1'b0, cur_cnt_q};
    i_end    = ({1'b0, PT_CNT_W'(i_q)} + (PT_CNT_W+1)'(1)) == {1'b0, prev_cnt_q};
  end

  assign prev_addr_o    = i_q;
  assign cur_addr_o     = u_q;
  assign rd_bank_o      = bank_q;
  assign idle_o         = (state_q == ST_IDLE);
  assign out_valid_o    = out_v_q;
  assign near_x_o       = out_near_x_q;
  assign near_y_o       = out_near_y_q;
  assign far_x_o        = out_far_x_q;
  assign far_y_o        = out_far_y_q;
  assign segment_last_o = out_last_q;

  // sequencer, held match and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      i_q           <= '0;
      u_q           <= '0;
      prev_cnt_q    <= '0;
      cur_cnt_q     <= '0;
      near_y_q      <= '0;
      far_y_q       <= '0;
      bank_q        <= 1'b0;
      pend_v_q      <= 1'b0;
      pend_near_x_q <= '0;
      pend_far_x_q  <= '0;
      out_v_q       <= 1'b0;
      out_near_x_q  <= '0;
      out_far_x_q   <= '0;
      out_near_y_q  <= '0;
      out_far_y_q   <= '0;
      out_last_q    <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            i_q        <= '0;
            u_q        <= '0;
            prev_cnt_q <= prev_cnt_i;
            cur_cnt_q  <= cur_cnt_i;
            near_y_q   <= req_i.near_y;
            far_y_q    <= req_i.far_y;
            bank_q     <= req_i.bank;
            state_q    <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (cmp_go) begin
            if (hit) begin
              if (pend_v_q) begin
                out_near_x_q <= pend_near_x_q;
                out_far_x_q  <= pend_far_x_q;
                out_near_y_q <= near_y_q;
                out_far_y_q  <= far_y_q;
                out_last_q   <= 1'b0;
              end
              pend_v_q      <= 1'b1;
              pend_near_x_q <= prev_x_i;
              pend_far_x_q  <= cur_x_i;
            end
            if (u_end) begin
              u_q <= '0;
              if (i_end) begin
                state_q <= ST_FLUSH;
              end else begin
                i_q     <= i_q + PT_IDX_W'(1);
                state_q <= ST_READ;
              end
            end else begin
              u_q     <= u_q + PT_IDX_W'(1);
              state_q <= ST_READ;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_near_x_q <= pend_near_x_q;
            out_far_x_q  <= pend_far_x_q;
            out_near_y_q <= near_y_q;
            out_far_y_q  <= far_y_q;
            out_last_q   <= 1'b1;
            pend_v_q     <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lane_marker_row_pair_matcher_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lane_marker_row_pair_matcher_core
// pairs edge pixels of scan rows into marker points and links points of
// adjacent rows into segments
// ----------------------------------------------------------------------------
// Pixels of a row stream at one per clock while no match walk holds the
// input. A row end item of a row other than the nearest one, when that row
// and the previous one both hold points, starts a walk over the stored
// points: each pair of a previous row point and a current row point is read
// from both point banks, then compared, and a final flush step emits the
// last match. The input is not ready from the row end until the walk ends,
// and stalls on the output side hold the walk. Points live in two banks of
// MAX_POINTS entries that swap roles at each row end, so no copy pass is
// needed.
module lane_marker_row_pair_matcher_core #(
  parameter int unsigned MAX_POINTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // row_slot[2:0], row_y[12:3], column[22:13], edge_req[23]
  input  wire logic [23:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,   // row_end
  // master side
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // near_x[10:0], near_y[20:11], far_x[31:21], far_y[41:32], zeros[47:42]
  output logic      [47:0] m_axis_tdata,
  output logic             m_axis_tlast,   // segment_last
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic [lmrp_pkg::IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lmrp_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import lmrp_pkg::*;

  localparam int unsigned PT_IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned PT_CNT_W = $clog2(MAX_POINTS + 1);

  logic [COL_W-1:0] x_offset_q;
  logic [COL_W-1:0] max_gap_q;
  logic [TOL_W-1:0] match_tol_q;

  logic                in_fire;
  logic                idle;
  logic                wr_en;
  logic                wr_bank;
  logic [PT_IDX_W-1:0] wr_addr;
  logic [X_W-1:0]      wr_data;
  match_req_t          req;
  logic [PT_CNT_W-1:0] prev_cnt;
  logic [PT_CNT_W-1:0] cur_cnt;
  logic [PT_IDX_W-1:0] prev_addr, cur_addr;
  logic                rd_bank;
  logic [PT_IDX_W-1:0] rd_addr0, rd_addr1;
  logic [X_W-1:0]      rd_data0, rd_data1;
  logic [X_W-1:0]      prev_x, cur_x;
  logic [X_W-1:0]      near_x, far_x;
  logic [Y_W-1:0]      near_y, far_y;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_offset_q  <= X_OFFSET_RST;
      max_gap_q   <= MAX_GAP_RST;
      match_tol_q <= MATCH_TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_OFFSET:  x_offset_q  <= cfg_wdata_i[COL_W-1:0];
        REG_MAX_GAP:   max_gap_q   <= cfg_wdata_i[COL_W-1:0];
        REG_MATCH_TOL: match_tol_q <= cfg_wdata_i[TOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input handshake
  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && idle;

  // edge pairing and bank bookkeeping
  lmrp_edge_unit #(
    .MAX_POINTS (MAX_POINTS),
    .PT_IDX_W   (PT_IDX_W),
    .PT_CNT_W   (PT_CNT_W)
  ) u_edge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .row_slot_i (s_axis_tdata[2:0]),
    .row_y_i    (s_axis_tdata[12:3]),
    .column_i   (s_axis_tdata[22:13]),
    .edge_req_i (s_axis_tdata[23]),
    .row_end_i  (s_axis_tlast),
    .x_offset_i (x_offset_q),
    .max_gap_i  (max_gap_q),
    .wr_en_o    (wr_en),
    .wr_bank_o  (wr_bank),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .req_o      (req),
    .prev_cnt_o (prev_cnt),
    .cur_cnt_o  (cur_cnt)
  );

  // bank address steering: rd_bank holds the closing row's points
  always_comb begin
    if (rd_bank) begin
      rd_addr0 = prev_addr;
      rd_addr1 = cur_addr;
      prev_x   = rd_data0;
      cur_x    = rd_data1;
    end else begin
      rd_addr0 = cur_addr;
      rd_addr1 = prev_addr;
      prev_x   = rd_data1;
      cur_x    = rd_data0;
    end
  end

  // point banks
  lmrp_point_ram #(
    .DEPTH  (MAX_POINTS),
    .WIDTH  (X_W),
    .ADDR_W (PT_IDX_W)
  ) u_bank0 (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en && !wr_bank),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr0),
    .rd_data_o (rd_data0)
  );

  lmrp_point_ram #(
    .DEPTH  (MAX_POINTS),
    .WIDTH  (X_W),
    .ADDR_W (PT_IDX_W)
  ) u_bank1 (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en && wr_bank),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr1),
    .rd_data_o (rd_data1)
  );

  // row pair walk and output register
  lmrp_match_seq #(
    .PT_IDX_W (PT_IDX_W),
    .PT_CNT_W (PT_CNT_W)
  ) u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .prev_cnt_i     (prev_cnt),
    .cur_cnt_i      (cur_cnt),
    .match_tol_i    (match_tol_q),
    .prev_x_i       (prev_x),
    .cur_x_i        (cur_x),
    .prev_addr_o    (prev_addr),
    .cur_addr_o     (cur_addr),
    .rd_bank_o      (rd_bank),
    .idle_o         (idle),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .near_x_o       (near_x),
    .near_y_o       (near_y),
    .far_x_o        (far_x),
    .far_y_o        (far_y),
    .segment_last_o (m_axis_tlast)
  );

  // output packing
  assign m_axis_tdata = {6'd0, far_y, far_x, near_y, near_x};

endmodule
`default_nettype wire

// ----- rtl/core/lmrp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmrp_checker
// port level checks of the lane marker row pair matcher over time
// ----------------------------------------------------------------------------
module lmrp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // a stalled result item holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result item changed");

  // a pixel that does not end a row never blocks the next pixel
  a_pixel_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !s_axis_tlast |=> s_axis_tready)
    else $error("input not ready after a plain pixel item");

  // the nearest row end emits nothing and frees the input at once
  a_near_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast && (s_axis_tdata[2:0] == 3'd0) |=> s_axis_tready)
    else $error("nearest row end started a match walk");

  // result items appear only out of a match walk
  a_out_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result item appeared while input was idle");

endmodule

bind lane_marker_row_pair_matcher_core lmrp_checker u_lmrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking regression for lane_marker_row_pair_matcher_core: scan rows
// of edge pixels stream in, a built-in predictor pairs edges into marker
// points and links points of adjacent rows, and every segment item that
// leaves the block is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module testbench;
  import lmrp_pkg::*;

  localparam int MAX_PTS       = 8;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 60;

  // one pixel item and one segment item
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [Y_W-1:0]    y;
    logic [COL_W-1:0]  col;
    logic              edge_req;
    logic              row_end;
  } pixel_t;

  typedef struct packed {
    logic [X_W-1:0] near_x;
    logic [Y_W-1:0] near_y;
    logic [X_W-1:0] far_x;
    logic [Y_W-1:0] far_y;
    logic           seg_last;
  } segment_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_we_i = 1'b0;
  logic [IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;

  lane_marker_row_pair_matcher_core #(
    .MAX_POINTS(MAX_PTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // pending pixels, predicted segments, bookkeeping
  pixel_t   pixel_q[$];
  segment_t segment_q[$];
  pixel_t   next_px;
  segment_t got_seg;
  int       n_items = 0;
  int       n_accepted = 0;
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  int       src_idle_pct = 25;
  int       sink_idle_pct = 25;
  int       hold_seq = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  // predictor copy of the configuration and the row state
  logic [COL_W-1:0] off_r = X_OFFSET_RST;
  logic [COL_W-1:0] gap_r = MAX_GAP_RST;
  logic [TOL_W-1:0] tol_r = MATCH_TOL_RST;
  logic [COL_W-1:0] last_edge = '0;
  logic [X_W-1:0]   cur_x [MAX_PTS];
  logic [X_W-1:0]   prev_x [MAX_PTS];
  int               cur_cnt = 0;
  int               prev_cnt = 0;
  logic [Y_W-1:0]   prev_y = '0;

  // lane generator settings for the current frame
  int lane_base [10];
  int lane_cnt;
  int lane_w;

  function automatic int absdiff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // pair an edge with the remembered one or make it the new memory
  task automatic update_lane_points(input logic [COL_W-1:0] col);
    int d;
    int hi;
    if (col != '0) begin
      d = absdiff(int'(col), int'(last_edge));
      if (last_edge != '0 && d > int'(MIN_SPACING) && d < int'(gap_r)) begin
        hi = (col > last_edge) ? int'(col) : int'(last_edge);
        if (cur_cnt < MAX_PTS) begin
          cur_x[cur_cnt] = X_W'(hi - d / 2 + int'(off_r));
          cur_cnt++;
        end
        last_edge = '0;
      end else begin
        last_edge = col;
      end
    end
  endtask

  // expected segments caused by one accepted pixel
  task automatic predict_pixel(input pixel_t px);
    int       n;
    int       k;
    segment_t s;
    if (px.edge_req) update_lane_points(px.col);
    if (px.row_end) begin
      if (px.slot != '0) begin
        n = 0;
        for (int i = 0; i < prev_cnt; i++)
          for (int u = 0; u < cur_cnt; u++)
            if (absdiff(int'(prev_x[i]), int'(cur_x[u])) <= int'(tol_r)) n++;
        k = 0;
        for (int i = 0; i < prev_cnt; i++) begin
          for (int u = 0; u < cur_cnt; u++) begin
            if (absdiff(int'(prev_x[i]), int'(cur_x[u])) <= int'(tol_r)) begin
              k++;
              s.near_x   = prev_x[i];
              s.near_y   = prev_y;
              s.far_x    = cur_x[u];
              s.far_y    = px.y;
              s.seg_last = (k == n);
              segment_q.push_back(s);
            end
          end
        end
      end
      prev_x    = cur_x;
      prev_cnt  = cur_cnt;
      prev_y    = px.y;
      cur_cnt   = 0;
      last_edge = '0;
    end
  endtask

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pixel('{slot: s_axis_tdata[2:0], y: s_axis_tdata[12:3],
                        col: s_axis_tdata[22:13], edge_req: s_axis_tdata[23],
                        row_end: s_axis_tlast});
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_px = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {next_px.edge_req, next_px.col, next_px.y, next_px.slot};
          s_axis_tlast  <= next_px.row_end;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      if (err_cnt < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // segment monitor and output back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= 0;
      hold_left     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (segment_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS)
            $display("%0t: segment with nothing expected, expected none, actual %h/%b",
                     $time, m_axis_tdata, m_axis_tlast);
          err_cnt++;
        end else begin
          got_seg = segment_q.pop_front();
          check_field("near_x", int'(got_seg.near_x), int'(m_axis_tdata[10:0]));
          check_field("near_y", int'(got_seg.near_y), int'(m_axis_tdata[20:11]));
          check_field("far_x", int'(got_seg.far_x), int'(m_axis_tdata[31:21]));
          check_field("far_y", int'(got_seg.far_y), int'(m_axis_tdata[41:32]));
          check_field("padding", 0, int'(m_axis_tdata[47:42]));
          check_field("segment_last", int'(got_seg.seg_last), int'(m_axis_tlast));
        end
      end
      // long hold-off on request, else random idling
      if (hold_seq != hold_seen) begin
        hold_seen     <= hold_seq;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("lane_marker_row_pair_matcher_core regression: fail");
      $finish;
    end
  end

  task automatic push_pixel(input int slot, input int y, input int col,
                            input int edge_req, input int row_end);
    pixel_t px;
    px.slot     = SLOT_W'(slot);
    px.y        = Y_W'(y);
    px.col      = COL_W'(col);
    px.edge_req = edge_req[0];
    px.row_end  = row_end[0];
    pixel_q.push_back(px);
    n_items++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(val);
    case (idx)
      REG_X_OFFSET:  off_r = COL_W'(val);
      REG_MAX_GAP:   gap_r = COL_W'(val);
      REG_MATCH_TOL: tol_r = TOL_W'(val);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender pause: every item taken, every segment seen, block walk finished
  task automatic wait_idle();
    while (n_accepted != n_items || segment_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // hand-built rows at reset settings
  task automatic run_directed();
    // nearest row: column zero ignored, one point at 20, row end edge at 1023 left unpaired
    push_pixel(0, 1023, 0, 1, 0);
    push_pixel(0, 1023, 10, 1, 0);
    push_pixel(0, 1023, 30, 1, 0);
    push_pixel(0, 1023, 1023, 1, 1);
    // out of order pair, too close edge, row end as an edge
    push_pixel(1, 500, 35, 1, 0);
    push_pixel(1, 500, 5, 1, 0);
    push_pixel(1, 500, 100, 1, 0);
    push_pixel(1, 500, 103, 1, 0);
    push_pixel(1, 500, 150, 1, 0);
    push_pixel(1, 500, 200, 0, 0);
    push_pixel(1, 500, 200, 1, 1);
    // gap of exactly max_gap, spacing of five, row end completes a pair
    push_pixel(2, 0, 100, 1, 0);
    push_pixel(2, 0, 150, 1, 0);
    push_pixel(2, 0, 155, 1, 0);
    push_pixel(2, 0, 161, 1, 0);
    push_pixel(2, 0, 200, 1, 0);
    push_pixel(2, 0, 220, 1, 1);
    // points one off from the previous row
    push_pixel(3, 7, 150, 1, 0);
    push_pixel(3, 7, 168, 1, 0);
    push_pixel(3, 7, 200, 1, 0);
    push_pixel(3, 7, 218, 1, 0);
    push_pixel(3, 7, 1023, 0, 1);
    // empty nearest row, then a row end with no previous points
    push_pixel(0, 512, 1023, 0, 1);
    push_pixel(5, 255, 1, 1, 1);
  endtask

  task automatic gen_row(input int slot, input int y);
    int l;
    int r;
    int last_col;
    last_col = 1;
    for (int k = 0; k < lane_cnt; k++) begin
      l = lane_base[k] + $urandom_range(0, 4);
      r = l + lane_w + $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) push_pixel(slot, y, l - 1, 0, 0);
      if ($urandom_range(0, 15) == 0) begin
        push_pixel(slot, y, r, 1, 0);
        push_pixel(slot, y, l, 1, 0);
      end else begin
        push_pixel(slot, y, l, 1, 0);
        push_pixel(slot, y, r, 1, 0);
      end
      last_col = r;
      if ($urandom_range(0, 15) == 0) begin
        last_col = r + $urandom_range(1, 5);
        push_pixel(slot, y, last_col, 1, 0);
      end
    end
    last_col = last_col + $urandom_range(1, 60);
    if (last_col > 1023) last_col = 1023;
    push_pixel(slot, y, last_col, $urandom_range(0, 1), 1);
  endtask

  // one frame of rows with lanes that drift a little from row to row
  task automatic gen_frame(input bit dense);
    int nrows;
    int y0;
    int ystep;
    lane_cnt = dense ? $urandom_range(8, 10) : $urandom_range(1, 4);
    for (int k = 0; k < lane_cnt; k++)
      lane_base[k] = dense ? 20 + k * 80 + $urandom_range(0, 10)
                           : 30 + k * 220 + $urandom_range(0, 100);
    lane_w = dense ? $urandom_range(6, 10) : $urandom_range(6, 40);
    nrows  = $urandom_range(2, 8);
    y0     = $urandom_range(nrows * 16, 1023);
    ystep  = $urandom_range(1, 16);
    for (int r = 0; r < nrows; r++) gen_row(r, y0 - r * ystep);
  endtask

  // arbitrary pixels, broken rows included
  task automatic gen_noise(input int count);
    for (int k = 0; k < count; k++)
      push_pixel($urandom_range(0, 7), $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 1), ($urandom_range(0, 3) == 0));
  endtask

  task automatic gen_phase(input int target, input int dense_pct);
    int start;
    start = n_items;
    while (n_items - start < target) begin
      if ($urandom_range(0, 99) < 80) gen_frame($urandom_range(0, 99) < dense_pct);
      else gen_noise($urandom_range(1, 6));
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    run_directed();
    wait_idle();

    // reset values written back explicitly
    write_reg(REG_X_OFFSET, 0);
    write_reg(REG_MAX_GAP, 50);
    write_reg(REG_MATCH_TOL, 1);
    gen_phase(100, 10);
    wait_idle();

    // upper extremes: every point pair matches, full point stores
    write_reg(REG_X_OFFSET, 1023);
    write_reg(REG_MAX_GAP, 1023);
    write_reg(REG_MATCH_TOL, 2047);
    hold_seq <= hold_seq + 1;
    gen_phase(100, 100);
    wait_idle();

    // lower extremes: no edge ever pairs
    write_reg(REG_X_OFFSET, $urandom_range(0, 1023));
    write_reg(REG_MAX_GAP, 6);
    write_reg(REG_MATCH_TOL, 0);
    gen_phase(60, 30);
    wait_idle();

    // stretch without any idling
    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    write_reg(REG_X_OFFSET, $urandom_range(0, 1023));
    write_reg(REG_MAX_GAP, $urandom_range(6, 1023));
    write_reg(REG_MATCH_TOL, $urandom_range(0, 4));
    gen_phase(100, 40);
    wait_idle();

    // random settings, wide tolerance
    src_idle_pct  <= 25;
    sink_idle_pct <= 25;
    write_reg(REG_X_OFFSET, $urandom_range(0, 1023));
    write_reg(REG_MAX_GAP, $urandom_range(6, 1023));
    write_reg(REG_MATCH_TOL, $urandom_range(0, 2047));
    gen_phase(100, 50);
    wait_idle();

    if (err_cnt == 0) begin
      $display("lane_marker_row_pair_matcher_core regression: pass");
    end else begin
      $display("lane_marker_row_pair_matcher_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lmrp_pkg.sv
rtl/core/lmrp_point_ram.sv
rtl/core/lmrp_edge_unit.sv
rtl/core/lmrp_match_seq.sv
rtl/core/lane_marker_row_pair_matcher_core.sv
rtl/core/lmrp_checker.sv
tb/testbench.sv
